[hw/rtl/bounded_uniform_rejection_sampler_top_assert.svh]
// Assertion macros for the bounded uniform rejection sampler checker.
// Expects signals named clk and arst_n in the scope where a macro is used.
`ifndef BOUNDED_UNIFORM_REJECTION_SAMPLER_TOP_ASSERT_SVH
`define BOUNDED_UNIFORM_REJECTION_SAMPLER_TOP_ASSERT_SVH

// Implication in the same cycle.
`define BRS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sampler assertion failed");

// Implication in the next cycle.
`define BRS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sampler assertion failed");

`endif

[hw/rtl/brs_pkg.sv]
// Package for the bounded uniform rejection sampler: cell and configuration types,
// word-size constants and the configuration decode function. No dependencies.
`timescale 1ns / 1ps

package brs_pkg;

	localparam int unsigned WordBits = 32;
	localparam int unsigned WidthBits = 6;
	// Narrowest chunk in the general case is two bits, so at most this many chunks.
	localparam int unsigned NumCells = WordBits / 2;
	localparam logic [WordBits-1:0] AllOnes = '1;

	typedef logic [WordBits-1:0] word_t;
	typedef logic [WidthBits-1:0] width_t;

	typedef struct packed {
		word_t  bound;        // exclusive upper bound n
		word_t  mask;         // all ones over the bit length of n
		width_t width;        // bit length of n
		logic   direct;       // n <= 1 or a power of two: no chunk search
		word_t  direct_mask;  // mask applied in the direct case
	} brs_cfg_t;

	typedef struct packed {
		logic  valid;
		logic  found;
		word_t word;          // remaining bits, current chunk in the low end
		word_t result;
	} brs_cell_t;

	function automatic width_t brs_bit_length(input word_t v);
		width_t len;
		len = '0;
		for (int i = 0; i < WordBits; i++) begin
			if (v[i]) len = width_t'(i + 1);
		end
		return len;
	endfunction

	function automatic brs_cfg_t brs_make_cfg(input word_t n);
		brs_cfg_t c;
		width_t   w;
		logic     small_n;
		logic     pow2;
		w = brs_bit_length(n);
		small_n = (n <= word_t'(1));
		pow2 = ((n & (n - word_t'(1))) == '0);
		c.bound = n;
		c.width = w;
		c.mask = AllOnes >> (width_t'(WordBits) - w);
		c.direct = small_n | pow2;
		c.direct_mask = small_n ? '0 : (n - word_t'(1));
		return c;
	endfunction

endpackage

[hw/rtl/brs_cell.sv]
// One cell of the chunk search chain: tests one chunk of the word against the bound.
// Depends on brs_pkg.
`timescale 1ns / 1ps

module brs_cell #(
	parameter int unsigned Index = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  brs_pkg::brs_cfg_t    cfg,
	input  brs_pkg::brs_cell_t   d,
	output brs_pkg::brs_cell_t   q
);
	import brs_pkg::*;

	// This cell holds chunk Index, which exists only if the chunk width fits Index + 1 times in the word.
	localparam width_t MaxWidth = width_t'(WordBits / (Index + 1));

	logic      active;
	logic      hit;
	word_t     chunk;
	logic      valid_q;
	logic      found_q;
	word_t     word_q;
	word_t     result_q;

	assign chunk  = d.word & cfg.mask;
	assign active = d.valid && !d.found && (cfg.width <= MaxWidth);
	assign hit    = active && (chunk < cfg.bound);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			found_q  <= d.found | hit;
			result_q <= hit ? chunk : d.result;
			word_q   <= d.word >> cfg.width;
		end
	end

	assign q = '{valid: valid_q, found: found_q, word: word_q, result: result_q};

endmodule

[hw/rtl/bounded_uniform_rejection_sampler_top.sv]
// Top level of the bounded uniform rejection sampler: configuration register,
// chain of brs_cell search cells and output register. Depends on brs_pkg, brs_cell.
`timescale 1ns / 1ps

// Each random word passes through a chain of 16 cells, one chunk tested per cell, and
// then an output register, which drives m_tvalid for the word. One word is taken every
// cycle while the output register is free or being emptied; the whole chain holds while
// a result waits in the output register. A rejected word gives no result. A bound of 0
// or 1 gives 0 for every word, and a power-of-two bound gives the word masked to the
// bound. The bound may only be changed while no word is in flight.
module bounded_uniform_rejection_sampler_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  brs_pkg::word_t        cfg_wdata,   // bound_limit
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  brs_pkg::word_t        s_tdata,     // [31:0] random_word
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output brs_pkg::word_t        m_tdata      // [31:0] bounded_value
);
	import brs_pkg::*;

	brs_cfg_t  cfg_q;
	brs_cell_t chain [0:NumCells];
	logic      advance;
	logic      m_valid_q;
	word_t     m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= brs_make_cfg('0);
		end else if (cfg_we) begin
			cfg_q <= brs_make_cfg(cfg_wdata);
		end
	end

	assign advance  = !m_valid_q || m_tready;
	assign s_tready = advance;

	// Direct cases are settled on entry and simply ride down the chain.
	assign chain[0] = '{
		valid:  s_tvalid,
		found:  cfg_q.direct,
		word:   s_tdata,
		result: s_tdata & cfg_q.direct_mask
	};

	for (genvar i = 0; i < NumCells; i++) begin : g_cell
		brs_cell #(
			.Index (i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (advance),
			.cfg    (cfg_q),
			.d      (chain[i]),
			.q      (chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= chain[NumCells].valid && chain[NumCells].found;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_data_q <= chain[NumCells].result;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

[hw/rtl/brs_checker.sv]
// Port-level checker for the bounded uniform rejection sampler, bound to the top level.
// Depends on brs_pkg and bounded_uniform_rejection_sampler_top_assert.svh.
`timescale 1ns / 1ps

`include "bounded_uniform_rejection_sampler_top_assert.svh"

module brs_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  brs_pkg::word_t  cfg_wdata,
	input  logic            s_tready,
	input  logic            m_tvalid,
	input  logic            m_tready,
	input  brs_pkg::word_t  m_tdata
);
	import brs_pkg::*;

	word_t bound_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_q <= '0;
		end else if (cfg_we) begin
			bound_q <= cfg_wdata;
		end
	end

	// The input side only backs off while a result is stuck in the output register.
	`BRS_ASSERT_NOW(a_ready_only_on_stall, !s_tready, m_tvalid && !m_tready)
	// A result that has not been taken stays offered.
	`BRS_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready, m_tvalid)
	// Every result lies below a bound of two or more.
	`BRS_ASSERT_NOW(a_result_in_range, m_tvalid && (bound_q >= word_t'(2)), m_tdata < bound_q)
	// With a bound of zero or one every result is zero.
	`BRS_ASSERT_NOW(a_small_bound_zero, m_tvalid && (bound_q <= word_t'(1)), m_tdata == '0)

endmodule

bind bounded_uniform_rejection_sampler_top brs_checker u_brs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_we    (cfg_we),
	.cfg_wdata (cfg_wdata),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata)
);
